// File: src/gnam_pkg.sv
// gnam_pkg: shared types, codes and constants of the gauge needle angle mapper
// depends on nothing; imported by every module of the block except gnam_ram
package gnam_pkg;

   // field widths
   localparam int VALUE_W   = 14;
   localparam int INDEX_W   = 5;
   localparam int ANGLE_W   = 16;
   localparam int GAIN_W    = 16;
   localparam int COUNT_W   = 6;
   localparam int SLEW_W    = 15;
   localparam int PROD_W    = VALUE_W + GAIN_W;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   // breakpoint words hold (k+1) * step for up to 32 segments
   localparam int BP_W = VALUE_W + 5;

   // default table depth
   localparam int MAX_SEGMENTS_DEF = 32;

   // register reset values
   localparam logic                 RST_ENABLE  = 1'b1;
   localparam logic [VALUE_W-1:0]   RST_STEP    = 14'd10;
   localparam logic [COUNT_W-1:0]   RST_COUNT   = 6'd20;
   localparam logic [VALUE_W-1:0]   RST_FLOOR   = 14'd0;
   localparam logic [VALUE_W-1:0]   RST_CEILING = 14'd210;
   localparam logic [SLEW_W-1:0]    RST_SLEW    = 15'd80;

   // fraction bits for rounding the Q18.12 product of value and Q4.12 gain
   localparam int FRAC_BITS = 12;

   // input item operations
   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_WRITE  = 1'b1
   } op_type;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE  = 3'd0,
      CSR_STEP    = 3'd1,
      CSR_COUNT   = 3'd2,
      CSR_FLOOR   = 3'd3,
      CSR_CEILING = 3'd4,
      CSR_SLEW    = 3'd5
   } csr_idx_type;

   // input beat
   typedef struct packed {
      logic                      op;
      logic [VALUE_W-1:0]        sample_value;
      logic [INDEX_W-1:0]        segment_index;
      logic signed [ANGLE_W-1:0] segment_offset;
      logic [GAIN_W-1:0]         segment_gain;
   } req_type;

   // result beat
   typedef struct packed {
      logic signed [ANGLE_W-1:0] needle_angle;
      logic [INDEX_W-1:0]        segment_used;
      logic                      slew_limited;
   } rsp_type;

   // static configuration seen by the datapath
   typedef struct packed {
      logic                 enable;
      logic [VALUE_W-1:0]   floor_val;
      logic [VALUE_W-1:0]   ceiling;
      logic [COUNT_W-1:0]   count;
      logic [SLEW_W-1:0]    slew;
   } cfg_type;

endpackage

// File: src/gnam_ram.sv
// gnam_ram: generic single write, single read memory with registered read
// depends on nothing
module gnam_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/gnam_csr.sv
// gnam_csr: configuration registers and the derived breakpoint words
// depends on gnam_pkg
module gnam_csr
   import gnam_pkg::*;
#(
   parameter int BP_N = 31
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_data,
   output cfg_type                     cfg,
   output logic [BP_N-1:0][BP_W-1:0]   bp
);

   cfg_type                   cfg_ff;
   logic [BP_N-1:0][BP_W-1:0] bp_ff;
   logic                      wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid && csr_ready;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable    <= RST_ENABLE;
         cfg_ff.floor_val <= RST_FLOOR;
         cfg_ff.ceiling   <= RST_CEILING;
         cfg_ff.count     <= RST_COUNT;
         cfg_ff.slew      <= RST_SLEW;
      end else if (wr) begin
         unique case (csr_idx_type'(csr_index))
            CSR_ENABLE:  cfg_ff.enable    <= csr_data[0];
            CSR_FLOOR:   cfg_ff.floor_val <= csr_data[VALUE_W-1:0];
            CSR_CEILING: cfg_ff.ceiling   <= csr_data[VALUE_W-1:0];
            CSR_COUNT:   cfg_ff.count     <= csr_data[COUNT_W-1:0];
            CSR_SLEW:    cfg_ff.slew      <= csr_data[SLEW_W-1:0];
            default: ;
         endcase
      end
   end

   // breakpoint k is (k+1) times the step, worked out once per step write
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < BP_N; k++) begin
            bp_ff[k] <= BP_W'(RST_STEP) * BP_W'(k + 1);
         end
      end else if (wr && csr_idx_type'(csr_index) == CSR_STEP) begin
         for (int k = 0; k < BP_N; k++) begin
            bp_ff[k] <= BP_W'(csr_data[VALUE_W-1:0]) * BP_W'(k + 1);
         end
      end
   end

   assign cfg = cfg_ff;
   assign bp  = bp_ff;

endmodule

// File: src/gnam_seg_select.sv
// gnam_seg_select: floor and ceiling clamp, then segment pick by breakpoints
// depends on gnam_pkg
module gnam_seg_select
   import gnam_pkg::*;
#(
   parameter int CAP  = 32,
   parameter int BP_N = 31
) (
   input  logic [VALUE_W-1:0]        sample_value,
   input  cfg_type                   cfg,
   input  logic [BP_N-1:0][BP_W-1:0] bp,
   output logic [VALUE_W-1:0]        value,
   output logic [INDEX_W-1:0]        seg
);

   logic [VALUE_W-1:0] diff;
   logic [COUNT_W-1:0] n_eff;
   logic [INDEX_W-1:0] last;
   logic [BP_N-1:0]    hit;

   // floor subtract clamped at zero, then ceiling cap
   always_comb begin
      if (sample_value > cfg.floor_val) begin
         diff = sample_value - cfg.floor_val;
      end else begin
         diff = '0;
      end
      if (diff > cfg.ceiling) begin
         value = cfg.ceiling;
      end else begin
         value = diff;
      end
   end

   // active count: zero acts as one, capped at the table size
   always_comb begin
      if (cfg.count == '0) begin
         n_eff = COUNT_W'(1);
      end else if (cfg.count > COUNT_W'(CAP)) begin
         n_eff = COUNT_W'(CAP);
      end else begin
         n_eff = cfg.count;
      end
      last = INDEX_W'(n_eff - COUNT_W'(1));
   end

   // parallel breakpoint compares
   always_comb begin
      for (int k = 0; k < BP_N; k++) begin
         hit[k] = (COUNT_W'(k + 1) < n_eff) && (BP_W'(value) <= bp[k]);
      end
   end

   // first hit wins, last active segment otherwise
   always_comb begin
      seg = last;
      for (int k = BP_N - 1; k >= 0; k--) begin
         if (hit[k]) begin
            seg = INDEX_W'(k);
         end
      end
   end

endmodule

// File: src/gnam_angle_calc.sv
// gnam_angle_calc: rounding, offset subtract, saturation and slew clamp
// depends on gnam_pkg
module gnam_angle_calc
   import gnam_pkg::*;
(
   input  logic [PROD_W-1:0]         prod,
   input  logic signed [ANGLE_W-1:0] offset,
   input  logic signed [ANGLE_W-1:0] prev,
   input  logic [SLEW_W-1:0]         slew,
   output logic signed [ANGLE_W-1:0] angle,
   output logic                      limited
);

   localparam int TERM_W = PROD_W + 1 - FRAC_BITS;
   localparam int RAW_W  = TERM_W + 2;
   localparam int LIM_W  = ANGLE_W + 1;

   logic [PROD_W:0]           rounded;
   logic [TERM_W-1:0]         term;
   logic signed [RAW_W-1:0]   term_s;
   logic signed [RAW_W-1:0]   raw;
   logic signed [ANGLE_W-1:0] sat;
   logic signed [LIM_W-1:0]   slew_s;
   logic signed [LIM_W-1:0]   lo;
   logic signed [LIM_W-1:0]   hi;
   logic signed [LIM_W-1:0]   sat_w;
   logic signed [LIM_W-1:0]   res;

   // round to nearest, halves up
   assign rounded = (PROD_W + 1)'(prod) + (PROD_W + 1)'(1 << (FRAC_BITS - 1));
   assign term    = rounded[PROD_W:FRAC_BITS];
   assign term_s  = {2'b00, term};
   assign raw     = RAW_W'(offset) - term_s;

   // saturate to the angle range
   always_comb begin
      if (raw < RAW_W'(-32768)) begin
         sat = 16'sh8000;
      end else if (raw > RAW_W'(32767)) begin
         sat = 16'sh7fff;
      end else begin
         sat = ANGLE_W'(raw);
      end
   end

   // slew window around the stored angle
   assign slew_s = {2'b00, slew};
   assign lo     = LIM_W'(prev) - slew_s;
   assign hi     = LIM_W'(prev) + slew_s;
   assign sat_w  = LIM_W'(sat);

   always_comb begin
      limited = 1'b0;
      res     = sat_w;
      if (sat_w < lo) begin
         res     = lo;
         limited = 1'b1;
      end else if (sat_w > hi) begin
         res     = hi;
         limited = 1'b1;
      end
      angle = ANGLE_W'(res);
   end

endmodule

// File: src/gauge_needle_angle_mapper.sv
// Gauge needle angle mapper: four-stage pipeline from accepted beat to result.
// Stages in order: input reg, table read, product reg, result reg; one beat
// per cycle sustained while rsp_stall is low, each stage moves on when the next is empty or moving.
// The slew clamp uses the stored angle of the previous sample in the last stage.
// Synchronous reset clears valids and stored angle and loads the configuration reset values; the segment
// tables are undefined until written and get no clearing pass.
module gauge_needle_angle_mapper
   import gnam_pkg::*;
#(
   parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int CAP   = MAX_SEGMENTS < 32 ? MAX_SEGMENTS : 32;
   localparam int BP_N  = CAP > 1 ? CAP - 1 : 1;
   localparam int IDX_W = MAX_SEGMENTS > 1 ? $clog2(MAX_SEGMENTS) : 1;
   localparam int WORD_W = ANGLE_W + GAIN_W;

   cfg_type                   cfg;
   logic [BP_N-1:0][BP_W-1:0] bp;

   // pipeline control
   logic adv_a, adv_b, adv_p, adv_c;
   logic a_valid_ff, a_valid_in;
   logic b_valid_ff, b_valid_in;
   logic p_valid_ff, p_valid_in;
   logic c_valid_ff, c_valid_in;
   logic a_is_sample, a_is_write;

   // pipeline payload
   req_type                   a_ff;
   logic [VALUE_W-1:0]        sel_value;
   logic [INDEX_W-1:0]        sel_seg;
   logic [VALUE_W-1:0]        b_value_ff;
   logic [INDEX_W-1:0]        b_seg_ff;
   logic [WORD_W-1:0]         rd_word;
   logic [PROD_W-1:0]         p_prod_ff, p_prod_in;
   logic signed [ANGLE_W-1:0] p_offset_ff;
   logic [INDEX_W-1:0]        p_seg_ff;
   rsp_type                   c_ff, c_in;
   logic signed [ANGLE_W-1:0] prev_ff;
   logic signed [ANGLE_W-1:0] calc_angle;
   logic                      calc_limited;
   logic                      wr_en;

   gnam_csr #(
      .BP_N (BP_N)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg),
      .bp        (bp)
   );

   // stage advance chain, bubbles collapse
   assign adv_c     = !c_valid_ff || !rsp_stall;
   assign adv_p     = !p_valid_ff || adv_c;
   assign adv_b     = !b_valid_ff || adv_p;
   assign adv_a     = !a_valid_ff || adv_b;
   assign req_stall = !adv_a;

   assign a_valid_in = adv_a ? req_valid : a_valid_ff;
   assign b_valid_in = adv_b ? a_is_sample : b_valid_ff;
   assign p_valid_in = adv_p ? b_valid_ff : p_valid_ff;
   assign c_valid_in = adv_c ? p_valid_ff : c_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         p_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         p_valid_ff <= p_valid_in;
         c_valid_ff <= c_valid_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (adv_a) begin
         a_ff <= req_payload;
      end
   end

   assign a_is_sample = a_valid_ff && op_type'(a_ff.op) == OP_SAMPLE && cfg.enable;
   assign a_is_write  = a_valid_ff && op_type'(a_ff.op) == OP_WRITE;

   // clamp and segment pick
   gnam_seg_select #(
      .CAP  (CAP),
      .BP_N (BP_N)
   ) u_sel (
      .sample_value (a_ff.sample_value),
      .cfg          (cfg),
      .bp           (bp),
      .value        (sel_value),
      .seg          (sel_seg)
   );

   // segment words written as the write beat leaves the input register, if its index is within the table
   assign wr_en = a_is_write && adv_b &&
                  (7'(a_ff.segment_index) < 7'(MAX_SEGMENTS));

   gnam_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_SEGMENTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (IDX_W'(a_ff.segment_index)),
      .wr_data ({a_ff.segment_offset, a_ff.segment_gain}),
      .rd_en   (adv_b),
      .rd_addr (IDX_W'(sel_seg)),
      .rd_data (rd_word)
   );

   // table read stage
   always_ff @(posedge clock) begin
      if (adv_b) begin
         b_value_ff <= sel_value;
         b_seg_ff   <= sel_seg;
      end
   end

   // product stage
   assign p_prod_in = PROD_W'(b_value_ff) * PROD_W'(rd_word[GAIN_W-1:0]);

   always_ff @(posedge clock) begin
      if (adv_p) begin
         p_prod_ff   <= p_prod_in;
         p_offset_ff <= rd_word[WORD_W-1:GAIN_W];
         p_seg_ff    <= b_seg_ff;
      end
   end

   // rounding, saturation and slew clamp
   gnam_angle_calc u_calc (
      .prod    (p_prod_ff),
      .offset  (p_offset_ff),
      .prev    (prev_ff),
      .slew    (cfg.slew),
      .angle   (calc_angle),
      .limited (calc_limited)
   );

   always_comb begin
      c_in.needle_angle = calc_angle;
      c_in.segment_used = p_seg_ff;
      c_in.slew_limited = calc_limited;
   end

   // result register
   always_ff @(posedge clock) begin
      if (adv_c) begin
         c_ff <= c_in;
      end
   end

   // stored angle follows every result
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else if (adv_c && p_valid_ff) begin
         prev_ff <= calc_angle;
      end
   end

   assign rsp_valid   = c_valid_ff;
   assign rsp_payload = c_ff;

   // the waiting result is the stored angle
   a_prev_match: assert property (@(posedge clock) disable iff (reset)
      c_valid_ff |-> c_ff.needle_angle == prev_ff)
      else $error("result angle differs from stored angle");

   // input stalls only with every stage full
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (a_valid_ff && b_valid_ff && p_valid_ff && c_valid_ff))
      else $error("input stalled with an empty stage");

   // a segment write never turns into a result
   a_write_drop: assert property (@(posedge clock) disable iff (reset)
      (a_is_write && adv_b) |=> !b_valid_ff)
      else $error("segment write entered the datapath");

   // applied segment lies within the active count
   a_seg_range: assert property (@(posedge clock) disable iff (reset)
      c_valid_ff |-> (COUNT_W'(c_ff.segment_used) < cfg.count
                      || c_ff.segment_used == '0))
      else $error("segment index beyond active count");

endmodule
